// File: hw/rtl/hile_pkg.sv
// Shared constants, types and lookup functions of the Hack line encoder.
package hile_pkg;

  // Default and largest supported line length.
  localparam int unsigned MaxLine     = 16;
  localparam int unsigned MaxLineHigh = 64;

  // Length counts saturate at MAX_LINE + 1 (at most MaxLineHigh + 1), positions stay below MaxLineHigh.
  localparam int unsigned LenW = $clog2(MaxLineHigh + 2);
  localparam int unsigned PosW = $clog2(MaxLineHigh);

  // Depth of the queue between the character front end and the decoder.
  localparam int unsigned QueueDepth = 2;

  // Result status codes.
  localparam logic [2:0] StCompute   = 3'd0;
  localparam logic [2:0] StAddress   = 3'd1;
  localparam logic [2:0] StLabel     = 3'd2;
  localparam logic [2:0] StSymbol    = 3'd3;
  localparam logic [2:0] StMalformed = 3'd4;
  localparam logic [2:0] StTooLarge  = 3'd5;

  // Up to three characters of one field of a compute line.
  typedef logic [2:0][7:0] field_txt_t;

  // Everything the decoder needs to know about one finished line.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [7:0]      first_char;
    logic [7:0]      last_char;
    logic [14:0]     number;
    logic            digits_only;
    logic            overflow;
    logic            eq_seen;
    logic [PosW-1:0] eq_pos;
    logic            semi_seen;
    logic [PosW-1:0] semi_pos;
    field_txt_t      dest_txt;
    field_txt_t      comp_txt;
    field_txt_t      jump_txt;
  } line_desc_t;

  // Result of a field lookup.
  typedef struct packed {
    logic       ok;
    logic [6:0] bits;
  } lookup_t;

  function automatic lookup_t dest_lookup(field_txt_t t, logic [LenW-1:0] n);
    lookup_t r;
    r = '{ok: 1'b1, bits: 7'd0};
    case (n)
      LenW'(1): begin
        case (t[0])
          "M":     r.bits = 7'd1;
          "D":     r.bits = 7'd2;
          "A":     r.bits = 7'd4;
          default: r.ok = 1'b0;
        endcase
      end
      LenW'(2): begin
        case ({t[0], t[1]})
          "MD":    r.bits = 7'd3;
          "AM":    r.bits = 7'd5;
          "AD":    r.bits = 7'd6;
          default: r.ok = 1'b0;
        endcase
      end
      LenW'(3): begin
        case ({t[0], t[1], t[2]})
          "AMD":   r.bits = 7'd7;
          default: r.ok = 1'b0;
        endcase
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t jump_lookup(field_txt_t t, logic [LenW-1:0] n);
    lookup_t r;
    r = '{ok: 1'b1, bits: 7'd0};
    if (n == LenW'(3)) begin
      case ({t[0], t[1], t[2]})
        "JGT":   r.bits = 7'd1;
        "JEQ":   r.bits = 7'd2;
        "JGE":   r.bits = 7'd3;
        "JLT":   r.bits = 7'd4;
        "JNE":   r.bits = 7'd5;
        "JLE":   r.bits = 7'd6;
        "JMP":   r.bits = 7'd7;
        default: r.ok = 1'b0;
      endcase
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // The a bit and c1..c6 of the compute field, swapped operand forms included.
  function automatic lookup_t comp_lookup(field_txt_t t, logic [LenW-1:0] n);
    lookup_t r;
    r = '{ok: 1'b1, bits: 7'd0};
    case (n)
      LenW'(1): begin
        case (t[0])
          "0":     r.bits = 7'h2A;
          "1":     r.bits = 7'h3F;
          "D":     r.bits = 7'h0C;
          "A":     r.bits = 7'h30;
          "M":     r.bits = 7'h70;
          default: r.ok = 1'b0;
        endcase
      end
      LenW'(2): begin
        case ({t[0], t[1]})
          "-1":    r.bits = 7'h3A;
          "!D":    r.bits = 7'h0D;
          "!A":    r.bits = 7'h31;
          "!M":    r.bits = 7'h71;
          "-D":    r.bits = 7'h0F;
          "-A":    r.bits = 7'h33;
          "-M":    r.bits = 7'h73;
          default: r.ok = 1'b0;
        endcase
      end
      LenW'(3): begin
        case ({t[0], t[1], t[2]})
          "D+1", "1+D": r.bits = 7'h1F;
          "A+1", "1+A": r.bits = 7'h37;
          "M+1", "1+M": r.bits = 7'h77;
          "D-1":        r.bits = 7'h0E;
          "A-1":        r.bits = 7'h32;
          "M-1":        r.bits = 7'h72;
          "D+A", "A+D": r.bits = 7'h02;
          "D+M", "M+D": r.bits = 7'h42;
          "D-A":        r.bits = 7'h13;
          "D-M":        r.bits = 7'h53;
          "A-D":        r.bits = 7'h07;
          "M-D":        r.bits = 7'h47;
          "D&A", "A&D": r.bits = 7'h00;
          "D&M", "M&D": r.bits = 7'h40;
          "D|A", "A|D": r.bits = 7'h15;
          "D|M", "M|D": r.bits = 7'h55;
          default:      r.ok = 1'b0;
        endcase
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/hile_if.sv
// Valid/ready channel interfaces for characters in and encoded words out.
interface hile_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink (input valid, input char_code, input line_end, output ready);
endinterface

interface hile_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_word;
  logic [2:0]  status;

  modport source (output valid, output code_word, output status, input ready);
  modport sink (input valid, input code_word, input status, output ready);
endinterface

// File: hw/rtl/hack_instruction_line_encoder_top.sv
// Top level of the Hack assembly line encoder: front end, queue and decoder.
//
//   Channel   Direction  Payload                      Transfers
//   in_ch_i   in         char_code[7:0], line_end     one per character
//   res_o     out        code_word[15:0], status[2:0]  one per line, at line end
//
// Characters are taken one per cycle, back to back, as long as the line queue has room.
// A line's result reaches res_o through the line queue and the output register: the
// transfer of its last character writes the line queue, and the line then moves
// through the decoder into the output register once that register is free or read.
// The output register and the two-entry line queue let the front end keep taking
// characters while a result waits on res_o; only a full queue stalls the input.
// Reset is asynchronous and active low; no clearing pass is needed after it.
module hack_instruction_line_encoder_top #(
  parameter int unsigned MAX_LINE = hile_pkg::MaxLine
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hile_char_if.sink   in_ch_i,
  hile_word_if.source res_o
);
  import hile_pkg::*;

  // Descriptor of a finished line, built by the front end at the line-end character.
  line_desc_t front_desc;
  logic       front_desc_valid;
  logic       queue_full;

  // Head of the queue as seen by the decoder.
  line_desc_t back_desc;
  logic       queue_empty;
  logic       back_pop;

  // The front end accumulates the line as it streams in: length, first character,
  // running decimal value and the up-to-three-character dest, comp and jump texts.
  hile_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ch_i         (in_ch_i),
    .desc_o       (front_desc),
    .desc_valid_o (front_desc_valid),
    .desc_ready_i (!queue_full)
  );

  // The queue decouples the character stream from result backpressure.
  hile_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_data_i (front_desc),
    .wr_en_i   (front_desc_valid),
    .full_o    (queue_full),
    .rd_data_o (back_desc),
    .empty_o   (queue_empty),
    .rd_en_i   (back_pop)
  );

  // The decoder turns one descriptor into status and word and holds it for res_o.
  hile_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (back_desc),
    .desc_valid_i (!queue_empty),
    .desc_pop_o   (back_pop),
    .res_o        (res_o)
  );

endmodule

// File: hw/rtl/hile_front.sv
// Character front end: counts, accumulates the decimal value and captures the fields.
module hile_front #(
  parameter int unsigned MAX_LINE = hile_pkg::MaxLine
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hile_char_if.sink            ch_i,
  output hile_pkg::line_desc_t desc_o,
  output logic                 desc_valid_o,
  input  logic                 desc_ready_i
);
  import hile_pkg::*;

  logic [LenW-1:0] cnt_q, cnt_d;
  logic [7:0]      first_q, first_d;
  logic [14:0]     num_q, num_d;
  logic            digits_q, digits_d;
  logic            ovf_q, ovf_d;
  logic            eq_seen_q, eq_seen_d;
  logic [PosW-1:0] eq_pos_q, eq_pos_d;
  logic            semi_seen_q, semi_seen_d;
  logic [PosW-1:0] semi_pos_q, semi_pos_d;
  field_txt_t      dest_q, dest_d;
  field_txt_t      comp_q, comp_d;
  field_txt_t      jump_q, jump_d;

  logic            accept;
  logic            in_range;
  logic            is_digit;
  logic            new_eq;
  logic            new_semi;
  logic [18:0]     num_next;
  logic [LenW-1:0] comp_start;
  logic [LenW-1:0] comp_rel;
  logic [LenW-1:0] jump_start;
  logic [LenW-1:0] jump_rel;
  logic [7:0]      ch;

  assign ch           = ch_i.char_code;
  assign ch_i.ready   = desc_ready_i;
  assign accept       = ch_i.valid && desc_ready_i;
  assign desc_valid_o = accept && ch_i.line_end;

  assign in_range   = cnt_q < LenW'(MAX_LINE);
  assign is_digit   = (ch >= "0") && (ch <= "9");
  assign new_eq     = in_range && !eq_seen_q && (ch == "=");
  assign new_semi   = in_range && !semi_seen_q && (ch == ";");
  assign num_next   = 19'({num_q, 3'b000}) + 19'({num_q, 1'b0}) + 19'(ch[3:0]);
  assign comp_start = eq_seen_q ? LenW'(eq_pos_q) + LenW'(1) : '0;
  assign comp_rel   = cnt_q - comp_start;
  assign jump_start = LenW'(semi_pos_q) + LenW'(1);
  assign jump_rel   = cnt_q - jump_start;

  always_comb begin
    cnt_d       = (cnt_q <= LenW'(MAX_LINE)) ? cnt_q + LenW'(1) : cnt_q;
    first_d     = (cnt_q == '0) ? ch : first_q;
    num_d       = num_q;
    digits_d    = digits_q;
    ovf_d       = ovf_q;
    eq_seen_d   = eq_seen_q || new_eq;
    eq_pos_d    = new_eq ? cnt_q[PosW-1:0] : eq_pos_q;
    semi_seen_d = semi_seen_q || new_semi;
    semi_pos_d  = new_semi ? cnt_q[PosW-1:0] : semi_pos_q;
    dest_d      = dest_q;
    comp_d      = comp_q;
    jump_d      = jump_q;

    // Decimal value of the characters after the first, held once too large.
    if (cnt_q != '0 && !ovf_q && digits_q && is_digit) begin
      if (num_next > 19'd32767) begin
        ovf_d = 1'b1;
      end else begin
        num_d = num_next[14:0];
      end
    end
    if (cnt_q != '0 && !is_digit) begin
      digits_d = 1'b0;
    end

    // The first three characters are the dest text; a new '=' starts the comp text.
    for (int i = 0; i < 3; i++) begin
      if (cnt_q == LenW'(i)) begin
        dest_d[i] = ch;
      end
      if (in_range && !new_eq && cnt_q >= comp_start && comp_rel == LenW'(i)) begin
        comp_d[i] = ch;
      end
      if (in_range && semi_seen_q && jump_rel == LenW'(i)) begin
        jump_d[i] = ch;
      end
    end
  end

  always_comb begin
    desc_o.len         = cnt_d;
    desc_o.first_char  = first_d;
    desc_o.last_char   = ch;
    desc_o.number      = num_d;
    desc_o.digits_only = digits_d;
    desc_o.overflow    = ovf_d;
    desc_o.eq_seen     = eq_seen_d;
    desc_o.eq_pos      = eq_pos_d;
    desc_o.semi_seen   = semi_seen_d;
    desc_o.semi_pos    = semi_pos_d;
    desc_o.dest_txt    = dest_d;
    desc_o.comp_txt    = comp_d;
    desc_o.jump_txt    = jump_d;
  end

  // Per-line control state returns to its start values after each line end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      num_q       <= '0;
      digits_q    <= 1'b1;
      ovf_q       <= 1'b0;
      eq_seen_q   <= 1'b0;
      semi_seen_q <= 1'b0;
    end else if (accept) begin
      if (ch_i.line_end) begin
        cnt_q       <= '0;
        num_q       <= '0;
        digits_q    <= 1'b1;
        ovf_q       <= 1'b0;
        eq_seen_q   <= 1'b0;
        semi_seen_q <= 1'b0;
      end else begin
        cnt_q       <= cnt_d;
        num_q       <= num_d;
        digits_q    <= digits_d;
        ovf_q       <= ovf_d;
        eq_seen_q   <= eq_seen_d;
        semi_seen_q <= semi_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q    <= first_d;
      eq_pos_q   <= eq_pos_d;
      semi_pos_q <= semi_pos_d;
      dest_q     <= dest_d;
      comp_q     <= comp_d;
      jump_q     <= jump_d;
    end
  end

endmodule

// File: hw/rtl/hile_fifo.sv
// Short queue of finished line descriptors between front end and decoder.
module hile_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hile_pkg::line_desc_t wr_data_i,
  input  logic                 wr_en_i,
  output logic                 full_o,
  output hile_pkg::line_desc_t rd_data_o,
  output logic                 empty_o,
  input  logic                 rd_en_i
);
  import hile_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  line_desc_t            mem_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q;
  logic [PtrW-1:0]       rd_ptr_q;
  logic [PtrW:0]         fill_q;
  logic                  push;
  logic                  pop;

  assign full_o    = fill_q == (PtrW + 1)'(QueueDepth);
  assign empty_o   = fill_q == '0;
  assign push      = wr_en_i && !full_o;
  assign pop       = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + (PtrW + 1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (PtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: hw/rtl/hile_back.sv
// Decoder: classifies a finished line, matches its fields and registers the result.
module hile_back #(
  parameter int unsigned MAX_LINE = hile_pkg::MaxLine
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hile_pkg::line_desc_t desc_i,
  input  logic                 desc_valid_i,
  output logic                 desc_pop_o,
  hile_word_if.source          res_o
);
  import hile_pkg::*;

  logic            out_valid_q;
  logic [15:0]     word_q;
  logic [2:0]      status_q;
  logic [15:0]     word_d;
  logic [2:0]      status_d;

  lookup_t         dest_r;
  lookup_t         comp_r;
  lookup_t         jump_r;
  logic [LenW-1:0] comp_from;
  logic [LenW-1:0] comp_to;
  logic [LenW-1:0] comp_len;
  logic [LenW-1:0] jump_len;
  logic            comp_span_ok;
  logic            is_compute_head;

  assign desc_pop_o = desc_valid_i && (!out_valid_q || res_o.ready);

  assign comp_from    = desc_i.eq_seen ? LenW'(desc_i.eq_pos) + LenW'(1) : '0;
  assign comp_to      = desc_i.semi_seen ? LenW'(desc_i.semi_pos) : desc_i.len;
  assign comp_span_ok = comp_to > comp_from;
  assign comp_len     = comp_span_ok ? comp_to - comp_from : '0;
  assign jump_len     = desc_i.len - LenW'(desc_i.semi_pos) - LenW'(1);

  assign dest_r = dest_lookup(desc_i.dest_txt, LenW'(desc_i.eq_pos));
  assign comp_r = comp_lookup(desc_i.comp_txt, comp_len);
  assign jump_r = jump_lookup(desc_i.jump_txt, jump_len);

  assign is_compute_head = (desc_i.first_char == "D") || (desc_i.first_char == "A") ||
                           (desc_i.first_char == "M") || (desc_i.first_char == "-") ||
                           (desc_i.first_char == "!") || (desc_i.first_char == "0") ||
                           (desc_i.first_char == "1");

  always_comb begin
    word_d   = '0;
    status_d = StMalformed;
    if (desc_i.len > LenW'(MAX_LINE) || desc_i.len == '0) begin
      status_d = StMalformed;
    end else if (desc_i.first_char == "@") begin
      if (desc_i.len == LenW'(1)) begin
        status_d = StMalformed;
      end else if (!desc_i.digits_only) begin
        status_d = StSymbol;
      end else if (desc_i.overflow) begin
        status_d = StTooLarge;
      end else begin
        status_d = StAddress;
        word_d   = {1'b0, desc_i.number};
      end
    end else if (desc_i.first_char == "(") begin
      status_d = (desc_i.last_char == ")") ? StLabel : StMalformed;
    end else if (is_compute_head) begin
      // A ';' ahead of the first '=', or any field that fails to match, is malformed.
      if (desc_i.eq_seen && desc_i.semi_seen && desc_i.semi_pos < desc_i.eq_pos) begin
        status_d = StMalformed;
      end else if (desc_i.eq_seen && !dest_r.ok) begin
        status_d = StMalformed;
      end else if (desc_i.semi_seen && !jump_r.ok) begin
        status_d = StMalformed;
      end else if (!comp_r.ok) begin
        status_d = StMalformed;
      end else begin
        status_d = StCompute;
        word_d   = {3'b111, comp_r.bits,
                    desc_i.eq_seen ? dest_r.bits[2:0] : 3'b000,
                    desc_i.semi_seen ? jump_r.bits[2:0] : 3'b000};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (desc_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_pop_o) begin
      word_q   <= word_d;
      status_q <= status_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.code_word = word_q;
  assign res_o.status    = status_q;

endmodule

// File: test/hack_instruction_line_encoder_top_test.sv
// Self-checking testbench of the Hack assembly line encoder top level.
`timescale 1ns / 100ps

module hack_instruction_line_encoder_top_test;
  import hile_pkg::*;

  // Line checker: keeps its own copy of the line state, predicts the status and the
  // machine word of every line at the transfer of its last character, and matches
  // the words that come out of the block against them in order.
  class line_encoding_checker;
    typedef struct packed {
      logic [15:0] word;
      logic [2:0]  status;
    } word_result_t;

    typedef enum {FieldDest, FieldComp, FieldJump} field_kind_e;

    // Mnemonic tables; dest and jump codes are the table index plus one.
    string dest_forms[7];
    string jump_forms[7];
    string comp_forms[37];
    int    comp_codes[37];

    // Line state as the block sees it.
    logic [7:0]  line_buf[MaxLine];
    int unsigned char_count;
    int unsigned num_value;
    bit          digits_only;
    bit          overflow;

    word_result_t awaited_words[$];
    int unsigned  failures;

    function new();
      dest_forms = '{"M", "D", "MD", "A", "AM", "AD", "AMD"};
      jump_forms = '{"JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
      comp_forms = '{"0", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D", "-A", "-M",
                     "D+1", "1+D", "A+1", "1+A", "M+1", "1+M", "D-1", "A-1", "M-1",
                     "D+A", "A+D", "D+M", "M+D", "D-A", "D-M", "A-D", "M-D",
                     "D&A", "A&D", "D&M", "M&D", "D|A", "A|D", "D|M", "M|D"};
      comp_codes = '{'h2A, 'h3F, 'h3A, 'h0C, 'h30, 'h70, 'h0D, 'h31, 'h71, 'h0F, 'h33,
                     'h73, 'h1F, 'h1F, 'h37, 'h37, 'h77, 'h77, 'h0E, 'h32, 'h72,
                     'h02, 'h02, 'h42, 'h42, 'h13, 'h53, 'h07, 'h47,
                     'h00, 'h00, 'h40, 'h40, 'h15, 'h15, 'h55, 'h55};
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      failures = 0;
      clear_line();
    endfunction

    function void clear_line();
      char_count  = 0;
      num_value   = 0;
      digits_only = 1'b1;
      overflow    = 1'b0;
    endfunction

    // True when line_buf[from +: n] spells the given mnemonic.
    function bit text_at(string form, int from, int n);
      if (form.len() != n) return 1'b0;
      for (int k = 0; k < n; k++) begin
        if (line_buf[from+k] != form[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Code of the field text in line_buf[from..to), or -1 when it is unknown.
    function int field_code(field_kind_e kind, int from, int to);
      int n;
      n = to - from;
      if (n <= 0 || n > 3) return -1;
      case (kind)
        FieldDest: begin
          for (int i = 0; i < 7; i++) if (text_at(dest_forms[i], from, n)) return i + 1;
        end
        FieldJump: begin
          for (int i = 0; i < 7; i++) if (text_at(jump_forms[i], from, n)) return i + 1;
        end
        default: begin
          for (int i = 0; i < 37; i++) begin
            if (text_at(comp_forms[i], from, n)) return comp_codes[i];
          end
        end
      endcase
      return -1;
    endfunction

    function word_result_t encode_compute(int n);
      word_result_t r;
      int eq;
      int semi;
      int comp_from;
      int comp_to;
      int d;
      int j;
      int c;
      r = '{word: 16'h0000, status: StMalformed};
      eq = -1;
      semi = -1;
      for (int i = n - 1; i >= 0; i--) begin
        if (line_buf[i] == "=") eq = i;
        if (line_buf[i] == ";") semi = i;
      end
      // A jump separator ahead of the first '=' can never form a valid line.
      if (eq >= 0 && semi >= 0 && semi < eq) return r;
      d = 0;
      j = 0;
      comp_from = 0;
      comp_to = n;
      if (eq >= 0) begin
        d = field_code(FieldDest, 0, eq);
        if (d < 0) return r;
        comp_from = eq + 1;
      end
      if (semi >= 0) begin
        j = field_code(FieldJump, semi + 1, n);
        if (j < 0) return r;
        comp_to = semi;
      end
      c = field_code(FieldComp, comp_from, comp_to);
      if (c < 0) return r;
      r.word = {3'b111, c[6:0], d[2:0], j[2:0]};
      r.status = StCompute;
      return r;
    endfunction

    function word_result_t encode_line();
      word_result_t r;
      logic [7:0] first;
      r = '{word: 16'h0000, status: StMalformed};
      if (char_count > MaxLine) return r;
      first = line_buf[0];
      if (first == "@") begin
        if (char_count == 1) r.status = StMalformed;
        else if (!digits_only) r.status = StSymbol;
        else if (overflow) r.status = StTooLarge;
        else begin
          r.word = {1'b0, num_value[14:0]};
          r.status = StAddress;
        end
      end else if (first == "(") begin
        r.status = (line_buf[char_count-1] == ")") ? StLabel : StMalformed;
      end else if (first == "D" || first == "A" || first == "M" || first == "-" ||
                   first == "!" || first == "0" || first == "1") begin
        r = encode_compute(char_count);
      end
      return r;
    endfunction

    // Called for every character transfer.
    function void take_char(logic [7:0] ch, bit last);
      bit is_digit;
      int unsigned v;
      is_digit = (ch >= "0" && ch <= "9");
      if (char_count < MaxLine) line_buf[char_count] = ch;
      if (char_count >= 1 && !overflow && digits_only && is_digit) begin
        v = num_value * 10 + (ch - 8'd48);
        if (v > 32767) begin
          overflow = 1'b1;
          v = 32768;
        end
        num_value = v;
      end
      if (char_count >= 1 && !is_digit) digits_only = 1'b0;
      if (char_count <= MaxLine) char_count++;
      if (last) begin
        awaited_words.push_back(encode_line());
        clear_line();
      end
    endfunction

    // Called for every result transfer.
    function void check_word(logic [15:0] word, logic [2:0] status);
      word_result_t exp_r;
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result, expected none, got word %h status %0d",
                 $time, word, status);
        failures++;
        return;
      end
      exp_r = awaited_words.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, exp_r.status, status);
        failures++;
      end
      if (word !== exp_r.word) begin
        $display("%0t: code word mismatch, expected %h, got %h", $time, exp_r.word, word);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hile_char_if in_ch ();
  hile_word_if res_ch ();

  hack_instruction_line_encoder_top #(
    .MAX_LINE(MaxLine)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch_i(in_ch),
    .res_o (res_ch)
  );

  line_encoding_checker sb = new();

  // Per-cycle chances, in percent, that the sender idles and the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned take_stall_pct;

  // Characters of the line being built, and the running count of sent characters.
  logic [7:0]  line_chars[$];
  int unsigned chars_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run time; the slowest legal run needs a small fraction of it.
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check each result transfer, then pick the ready level for the next
  // cycle. Ready gets exactly one assignment per clock edge.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) begin
        sb.check_word(res_ch.code_word, res_ch.status);
      end
      res_ch.ready <= ($urandom_range(0, 99) >= take_stall_pct);
    end
  end

  // Offers one character and returns at the edge of its transfer. Valid stays high
  // after the transfer so that back-to-back characters need no extra assignment;
  // the next call, or a drain, lowers it if the sender is to idle.
  task automatic send_char(input logic [7:0] ch, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= ch;
    in_ch.line_end  <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.take_char(ch, last);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_chars.size(); i++) begin
      send_char(line_chars[i], i == line_chars.size() - 1);
    end
    chars_sent += line_chars.size();
    line_chars.delete();
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    push_text(s);
    send_line();
  endtask

  // Stops offering characters until every predicted word has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited_words.size() != 0);
  endtask

  function automatic logic [7:0] pick_char(string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // A well-formed compute line: optional dest, any comp form, optional jump.
  function automatic void build_compute();
    if ($urandom_range(0, 1)) push_text({sb.dest_forms[$urandom_range(0, 6)], "="});
    push_text(sb.comp_forms[$urandom_range(0, 36)]);
    if ($urandom_range(0, 1)) push_text({";", sb.jump_forms[$urandom_range(0, 6)]});
  endfunction

  // Decimal address lines, weighted toward the 15-bit limit and with leading zeros
  // now and then; a few run past the line length.
  function automatic void build_address();
    int unsigned v;
    int unsigned zeros;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 9);
      1: v = $urandom_range(0, 32767);
      2: v = $urandom_range(32760, 32775);
      3: v = $urandom_range(32768, 999999);
      4: v = $urandom_range(65530, 65545);
      default: v = $urandom_range(0, 999);
    endcase
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    push_text("@");
    repeat (zeros) push_text("0");
    push_text($sformatf("%0d", v));
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(8, 14)) line_chars.push_back(pick_char("0123456789"));
    end
  endfunction

  // "@" followed by text with at least one non-digit.
  function automatic void build_symbol();
    push_text("@");
    repeat ($urandom_range(0, 3)) line_chars.push_back(pick_char("0123456789"));
    line_chars.push_back(pick_char("ABCLOOPxyz_.$:"));
    repeat ($urandom_range(0, 5)) line_chars.push_back(pick_char("ENDloop0123_"));
  endfunction

  function automatic void build_label();
    push_text("(");
    repeat ($urandom_range(0, 10)) line_chars.push_back(pick_char("ABCDLOOPEND_.$9"));
    if ($urandom_range(0, 6) != 0) push_text(")");
    else line_chars.push_back(pick_char("X(]0"));
  endfunction

  // A compute line with one character replaced, dropped or added.
  function automatic void build_broken();
    int unsigned pos;
    logic [7:0] ch;
    build_compute();
    pos = $urandom_range(0, line_chars.size() - 1);
    ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pick_char("=;DAM01-!+&|JXG");
    case ($urandom_range(0, 2))
      0: line_chars[pos] = ch;
      1: if (line_chars.size() > 1) line_chars.delete(pos);
      default: line_chars.insert(pos, ch);
    endcase
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, MaxLine + 4)) line_chars.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Lines just past the length limit, built from otherwise valid text.
  function automatic void build_overlong();
    case ($urandom_range(0, 2))
      0: build_compute();
      1: build_label();
      default: build_address();
    endcase
    while (line_chars.size() <= MaxLine + $urandom_range(0, 3)) begin
      line_chars.insert(1, pick_char("0123AMD+"));
    end
  endfunction

  task automatic send_random_line();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) build_compute();
    else if (pick < 57) build_address();
    else if (pick < 63) build_symbol();
    else if (pick < 69) build_label();
    else if (pick < 85) build_broken();
    else if (pick < 93) build_noise();
    else build_overlong();
    send_line();
  endtask

  initial begin
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set  = '{0, 78, 0, 17};
    stall_set = '{0, 0, 78, 17};
    send_idle_pct   = 0;
    take_stall_pct  = 0;
    chars_sent      = 0;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= 8'h00;
    in_ch.line_end  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: address limits, bare and symbolic addresses, labels with and
    // without a closing parenthesis, compute lines with all three fields, empty and
    // unknown fields, a jump ahead of the dest, unknown first characters and lines
    // at and past the length limit.
    send_text("@0");
    send_text("@32767");
    send_text("@32768");
    send_text("@65535");
    send_text("@");
    send_text("@LOOP");
    send_text("@12x");
    send_text("(END)");
    send_text("()");
    send_text("(END");
    send_text("AMD=D|M;JMP");
    send_text("0;JMP");
    send_text("M=1+M");
    send_text("A=!D;JNE");
    send_text("-1");
    send_text("D;JXX");
    send_text("=D");
    send_text("D=");
    send_text("D;");
    send_text("D;JGT=A");
    send_text("x");
    send_text("@000000000032767");
    send_text("(ABCDEFGHIJKLMN)");
    send_text("AMD=D+1;JMP00000");
    send_text("AMD=D+1;JMP000000");
    line_chars.push_back(8'hFF);
    line_chars.push_back(8'h00);
    send_line();

    // Hold the sender off until the decoder has handed over everything it owes.
    wait_drained();

    // Random lines under four idling patterns; the third starts from an empty block.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p];
      take_stall_pct = stall_set[p];
      if (p == 2) wait_drained();
      chars_sent = 0;
      while (chars_sent < 160) send_random_line();
    end

    wait_drained();
    take_stall_pct = 0;
    repeat (10) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/hile_pkg.sv
hw/rtl/hile_if.sv
hw/rtl/hile_front.sv
hw/rtl/hile_fifo.sv
hw/rtl/hile_back.sv
hw/rtl/hack_instruction_line_encoder_top.sv
test/hack_instruction_line_encoder_top_test.sv
